/* design/tgf_pkg.sv */
// Shared types for the triangle geometric factors block.
// Used by the front, queue, back and top-level files; depends on nothing.
package tgf_pkg;

    // Occupancy flags of the queue between the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } tgf_qstat_t;

    // Number of metric terms worked out in parallel in the back.
    localparam int unsigned LANES = 4;

    // Lanes whose numerator is negated: ry = -hxs/J and sx = -hyr/J.
    localparam logic [LANES-1:0] LANE_FLIP = 4'b0110;

endpackage

/* design/tgf_front.sv */
// Front of the triangle geometric factors block: takes items, forms the
// half-differences, the two cross products, the Jacobian and the degenerate flag.
// Depends on tgf_pkg.
module tgf_front #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [W-1:0]        x0_coord,
    input  logic [W-1:0]        y0_coord,
    input  logic [W-1:0]        x1_coord,
    input  logic [W-1:0]        y1_coord,
    input  logic [W-1:0]        x2_coord,
    input  logic [W-1:0]        y2_coord,
    input  logic                last_element,
    input  tgf_pkg::tgf_qstat_t qstat,
    output logic                push,
    output logic [6*W+2:0]      entry
);

    logic              en;
    logic [W:0]        dxr, dxs, dyr, dys;
    logic              va_reg;
    logic [W-1:0]      hxr_a_reg, hxs_a_reg, hyr_a_reg, hys_a_reg;
    logic              last_a_reg;
    logic              vb_reg;
    logic [W-1:0]      hxr_b_reg, hxs_b_reg, hyr_b_reg, hys_b_reg;
    logic              last_b_reg;
    logic [2*W-1:0]    pa_reg, pb_reg;
    logic [2*W:0]      p_next;
    logic              zero_next;

    // The whole front moves together and holds while the queue is full.
    assign en       = !qstat.full;
    assign in_stall = qstat.full;

    // Exact differences; dropping the low bit is an arithmetic shift right by one.
    assign dxr = {x1_coord[W-1], x1_coord} - {x0_coord[W-1], x0_coord};
    assign dxs = {x2_coord[W-1], x2_coord} - {x0_coord[W-1], x0_coord};
    assign dyr = {y1_coord[W-1], y1_coord} - {y0_coord[W-1], y0_coord};
    assign dys = {y2_coord[W-1], y2_coord} - {y0_coord[W-1], y0_coord};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hxr_a_reg  <= dxr[W:1];
            hxs_a_reg  <= dxs[W:1];
            hyr_a_reg  <= dyr[W:1];
            hys_a_reg  <= dys[W:1];
            last_a_reg <= last_element;
            pa_reg     <= (2*W)'($signed(hxr_a_reg) * $signed(hys_a_reg));
            pb_reg     <= (2*W)'($signed(hxs_a_reg) * $signed(hyr_a_reg));
            hxr_b_reg  <= hxr_a_reg;
            hxs_b_reg  <= hxs_a_reg;
            hyr_b_reg  <= hyr_a_reg;
            hys_b_reg  <= hys_a_reg;
            last_b_reg <= last_a_reg;
        end
    end

    assign p_next    = {pa_reg[2*W-1], pa_reg} - {pb_reg[2*W-1], pb_reg};
    assign zero_next = (p_next == '0);
    assign push      = vb_reg && en;
    assign entry     = {last_b_reg, zero_next, p_next,
                        hxr_b_reg, hxs_b_reg, hyr_b_reg, hys_b_reg};

endmodule

/* design/tgf_queue.sv */
// Short item queue between the front and the back.
// Depends on tgf_pkg.
module tgf_queue #(
    parameter int EW = 195
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [EW-1:0]       din,
    input  logic                pop,
    output logic [EW-1:0]       dout,
    output tgf_pkg::tgf_qstat_t qstat
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [EW-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout        = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == (AW+1)'(DEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule

/* design/tgf_back.sv */
// Back of the triangle geometric factors block: four pipelined restoring
// dividers that round to nearest, one quotient bit per stage, then signs and saturation.
// Depends on tgf_pkg.
module tgf_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [6*W+2:0]      head,
    input  tgf_pkg::tgf_qstat_t qstat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [W-1:0]        rx_term,
    output logic [W-1:0]        ry_term,
    output logic [W-1:0]        sx_term,
    output logic [W-1:0]        sy_term,
    output logic [W-1:0]        jacobian,
    output logic                degenerate,
    output logic                last_result
);

    localparam int L  = tgf_pkg::LANES;
    localparam int DW = 2*W;
    localparam int NW = (((W+2*F) > (2*W-1)) ? (W+2*F) : (2*W-1)) + 1;
    localparam logic [NW-1:0] LIM = NW'(1) << (W-1);
    localparam logic [W-1:0]  SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SMIN = {1'b1, {(W-1){1'b0}}};

    logic              en;
    logic [2*W:0]      p;
    logic [2*W:0]      pabs;
    logic [DW-1:0]     d_next;
    logic [W-1:0]      h [0:L-1];
    logic [NW-1:0]     dvd_next [0:L-1];
    logic [L-1:0]      sg_next;
    logic [2*W+1:0]    jt, js;
    logic              jok;
    logic [W-1:0]      jac_next;

    logic              v_reg    [0:NW];
    logic [DW-1:0]     a_reg    [0:NW][0:L-1];
    logic [NW-1:0]     q_reg    [0:NW][0:L-1];
    logic [DW-1:0]     d_reg    [0:NW];
    logic [L-1:0]      sg_reg   [0:NW];
    logic [W-1:0]      jac_reg  [0:NW];
    logic              dg_reg   [0:NW];
    logic              last_reg [0:NW];

    logic              vo_reg;
    logic [W-1:0]      t_reg [0:L-1];
    logic [W-1:0]      jo_reg;
    logic              dgo_reg, lo_reg;
    logic [W-1:0]      t_next [0:L-1];

    // The back moves as one pipeline whenever the output register can take an item.
    assign en  = !vo_reg || !out_stall;
    assign pop = en && !qstat.empty;

    assign p    = head[6*W:4*W];
    assign pabs = p[2*W] ? -p : p;
    assign d_next = pabs[DW-1:0];

    assign h[0] = head[W-1:0];
    assign h[1] = head[3*W-1:2*W];
    assign h[2] = head[2*W-1:W];
    assign h[3] = head[4*W-1:3*W];

    // Rounding to nearest, ties away from zero, is done on magnitudes by adding
    // half the divisor to the dividend before dividing.
    always_comb
    begin
        for (int k = 0; k < L; k++)
        begin
            dvd_next[k] = NW'({(h[k][W-1] ? -h[k] : h[k]), {(2*F){1'b0}}})
                          + NW'(d_next >> 1);
            sg_next[k]  = h[k][W-1] ^ tgf_pkg::LANE_FLIP[k] ^ p[2*W];
        end
    end

    assign jt  = {p[2*W], p} + ((2*W+2)'(1) << (F-1));
    assign js  = $signed(jt) >>> F;
    assign jok = (js[2*W+1:W-1] == '0) || (js[2*W+1:W-1] == '1);
    assign jac_next = jok ? js[W-1:0] : (js[2*W+1] ? SMIN : SMAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= !qstat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < L; k++)
            begin
                a_reg[0][k] <= '0;
                q_reg[0][k] <= dvd_next[k];
            end
            d_reg[0]    <= d_next;
            sg_reg[0]   <= sg_next;
            jac_reg[0]  <= jac_next;
            dg_reg[0]   <= head[6*W+1];
            last_reg[0] <= head[6*W+2];
        end
    end

    for (genvar g = 1; g <= NW; g++)
    begin : g_stage
        logic [DW:0]   sh   [0:L-1];
        logic [DW:0]   diff [0:L-1];

        for (genvar k = 0; k < L; k++)
        begin : g_lane
            assign sh[k]   = {a_reg[g-1][k], q_reg[g-1][k][NW-1]};
            assign diff[k] = sh[k] - {1'b0, d_reg[g-1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < L; k++)
                begin
                    a_reg[g][k] <= diff[k][DW] ? sh[k][DW-1:0] : diff[k][DW-1:0];
                    q_reg[g][k] <= {q_reg[g-1][k][NW-2:0], !diff[k][DW]};
                end
                d_reg[g]    <= d_reg[g-1];
                sg_reg[g]   <= sg_reg[g-1];
                jac_reg[g]  <= jac_reg[g-1];
                dg_reg[g]   <= dg_reg[g-1];
                last_reg[g] <= last_reg[g-1];
            end
        end
    end

    // Apply the quotient sign and saturate; a degenerate triangle gives zeros.
    always_comb
    begin
        for (int k = 0; k < L; k++)
        begin
            if (dg_reg[NW])
            begin
                t_next[k] = '0;
            end
            else if (!sg_reg[NW][k])
            begin
                t_next[k] = (q_reg[NW][k] >= LIM) ? SMAX : q_reg[NW][k][W-1:0];
            end
            else
            begin
                t_next[k] = (q_reg[NW][k] > LIM) ? SMIN : (-q_reg[NW][k][W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= v_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < L; k++)
            begin
                t_reg[k] <= t_next[k];
            end
            jo_reg  <= dg_reg[NW] ? '0 : jac_reg[NW];
            dgo_reg <= dg_reg[NW];
            lo_reg  <= last_reg[NW];
        end
    end

    assign out_valid   = vo_reg;
    assign rx_term     = t_reg[0];
    assign ry_term     = t_reg[1];
    assign sx_term     = t_reg[2];
    assign sy_term     = t_reg[3];
    assign jacobian    = jo_reg;
    assign degenerate  = dgo_reg;
    assign last_result = lo_reg;

endmodule

/* design/triangle_geometric_factors.sv */
// Top level of the triangle geometric factors block.
// Depends on tgf_pkg, tgf_front, tgf_queue and tgf_back.
//
// One input item carries the three vertices of a triangle in signed fixed point
// and a last marker; one result item carries rx, ry, sx, sy, the Jacobian, a
// degenerate flag and the marker. Both channels use valid and stall, and an
// item moves on a clock edge where valid is high and stall is low.
// The block takes one item every cycle while in_stall is low. On its way to
// its result an item passes the front, the queue, the four dividers, which
// produce one quotient bit per pipeline stage, and the output register.
// The front holds its two stages and raises in_stall only while the four-entry
// queue is full; the back holds its whole divider pipeline while a result
// waits under out_stall, so the queue soaks up the front's items.
// Reset empties the queue and clears every valid bit; nothing else is cleared.
module triangle_geometric_factors #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COORD_WIDTH-1:0] x0_coord,
    input  logic [COORD_WIDTH-1:0] y0_coord,
    input  logic [COORD_WIDTH-1:0] x1_coord,
    input  logic [COORD_WIDTH-1:0] y1_coord,
    input  logic [COORD_WIDTH-1:0] x2_coord,
    input  logic [COORD_WIDTH-1:0] y2_coord,
    input  logic                   last_element,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COORD_WIDTH-1:0] rx_term,
    output logic [COORD_WIDTH-1:0] ry_term,
    output logic [COORD_WIDTH-1:0] sx_term,
    output logic [COORD_WIDTH-1:0] sy_term,
    output logic [COORD_WIDTH-1:0] jacobian,
    output logic                   degenerate,
    output logic                   last_result
);

    localparam int EW = 6*COORD_WIDTH + 3;

    logic                push, pop;
    logic [EW-1:0]       entry, head;
    tgf_pkg::tgf_qstat_t qstat;

    tgf_front #(
        .W (COORD_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x0_coord     (x0_coord),
        .y0_coord     (y0_coord),
        .x1_coord     (x1_coord),
        .y1_coord     (y1_coord),
        .x2_coord     (x2_coord),
        .y2_coord     (y2_coord),
        .last_element (last_element),
        .qstat        (qstat),
        .push         (push),
        .entry        (entry)
    );

    tgf_queue #(
        .EW (EW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (entry),
        .pop   (pop),
        .dout  (head),
        .qstat (qstat)
    );

    tgf_back #(
        .W (COORD_WIDTH),
        .F (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rx_term     (rx_term),
        .ry_term     (ry_term),
        .sx_term     (sx_term),
        .sy_term     (sy_term),
        .jacobian    (jacobian),
        .degenerate  (degenerate),
        .last_result (last_result)
    );

    // A degenerate triangle always leaves with all metric terms and J at zero.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> rx_term == '0 && ry_term == '0 &&
        sx_term == '0 && sy_term == '0 && jacobian == '0)
        else $error("degenerate result with nonzero terms");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("queue overflow");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue underflow");

    // While a result is held, the back takes nothing from the queue.
    a_hold_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !pop)
        else $error("pop while output stalled");

endmodule

/* tb/sv/tb_triangle_geometric_factors.sv */
// Self-checking testbench for triangle_geometric_factors: directed table, then random triangles.
// Depends only on the block itself; results are compared with typed table values or an in-bench predictor.
module tb_triangle_geometric_factors;

    localparam int W          = 32;
    localparam int RAND_ITEMS = 1830;
    localparam int WD_LIMIT   = 4000;
    localparam int DRAIN      = 100;
    localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
    localparam logic signed [127:0] SAT_LO = -128'sd2147483648;

    typedef struct {
        logic signed [W-1:0] x0, y0, x1, y1, x2, y2;
        logic                last;
    } tri_t;

    typedef struct {
        logic signed [W-1:0] rx, ry, sx, sy, jac;
        logic                degen, last;
    } factors_t;

    typedef struct {
        tri_t     t;
        logic     typed;
        factors_t f;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         in_valid, in_stall, last_element;
    logic [W-1:0] x0_coord, y0_coord, x1_coord, y1_coord, x2_coord, y2_coord;
    logic         out_valid, out_stall;
    logic [W-1:0] rx_term, ry_term, sx_term, sy_term, jacobian;
    logic         degenerate, last_result;

    factors_t factors_due[$];
    int       errors = 0;
    int       results_seen = 0;
    int       degen_seen = 0;
    int       sent = 0;
    int       quiet_cycles = 0;
    logic     idle_on = 1'b1;

    triangle_geometric_factors DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [W-1:0] clamp(logic signed [127:0] v);
        if (v > SAT_HI)
            return SAT_HI[W-1:0];
        if (v < SAT_LO)
            return SAT_LO[W-1:0];
        return v[W-1:0];
    endfunction

    // Signed quotient rounded to nearest, ties away from zero.
    function automatic logic signed [127:0] round_quot(logic signed [127:0] n,
                                                       logic signed [127:0] d);
        logic [127:0] mn, md, q;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        q  = (mn + (md >> 1)) / md;
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic factors_t predict_factors(tri_t t);
        logic signed [127:0] hxr, hxs, hyr, hys, p, a, b;
        factors_t f;
        a = t.x1; b = t.x0; hxr = (a - b) >>> 1;
        a = t.x2;           hxs = (a - b) >>> 1;
        a = t.y1; b = t.y0; hyr = (a - b) >>> 1;
        a = t.y2;           hys = (a - b) >>> 1;
        p = hxr * hys - hxs * hyr;
        f.last = t.last;
        if (p == 0)
        begin
            f.rx = '0; f.ry = '0; f.sx = '0; f.sy = '0; f.jac = '0;
            f.degen = 1'b1;
            return f;
        end
        f.rx    = clamp(round_quot(hys <<< 32, p));
        f.ry    = clamp(round_quot(-(hxs <<< 32), p));
        f.sx    = clamp(round_quot(-(hyr <<< 32), p));
        f.sy    = clamp(round_quot(hxr <<< 32, p));
        f.jac   = clamp((p + 128'sd32768) >>> 16);
        f.degen = 1'b0;
        return f;
    endfunction

    function automatic row_t mk_row(int x0, int y0, int x1, int y1, int x2, int y2,
                                    logic last, logic typed, int rx, int ry,
                                    int sx, int sy, int jac, logic degen);
        row_t r;
        r.t = '{x0, y0, x1, y1, x2, y2, last};
        r.typed = typed;
        r.f = '{rx, ry, sx, sy, jac, degen, last};
        return r;
    endfunction

    // Drives one item, with random idle cycles ahead of it while idle_on is set, and waits until it is taken.
    task automatic send_triangle(tri_t t, logic typed, factors_t f);
        while (idle_on && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        x0_coord     <= t.x0; y0_coord <= t.y0;
        x1_coord     <= t.x1; y1_coord <= t.y1;
        x2_coord     <= t.x2; y2_coord <= t.y2;
        last_element <= t.last;
        do
            @(posedge clk);
        while (in_stall);
        factors_due.push_back(typed ? f : predict_factors(t));
        sent++;
    endtask

    function automatic logic signed [W-1:0] rand_coord(int unsigned kind);
        logic signed [W-1:0] v;
        case (kind)
            0: v = $urandom;
            1: v = $signed($urandom_range(2097152)) - 1048576;
            2: v = $signed($urandom_range(64)) - 32;
            default: v = $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                           : 32'sh80000000 + $urandom_range(3);
        endcase
        return v;
    endfunction

    function automatic tri_t rand_triangle();
        tri_t t;
        int unsigned kind, shape;
        kind  = $urandom_range(9);
        kind  = (kind < 3) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
        shape = $urandom_range(9);
        t.x0 = rand_coord(kind); t.y0 = rand_coord(kind);
        t.x1 = rand_coord(kind); t.y1 = rand_coord(kind);
        t.x2 = rand_coord(kind); t.y2 = rand_coord(kind);
        // A share of collinear triangles exercises the zero Jacobian path.
        if (shape == 0)
        begin
            t.x2 = t.x1; t.y2 = t.y1;
        end
        else if (shape == 1)
        begin
            t.x1 = t.x0; t.y1 = t.y0;
        end
        t.last = ($urandom_range(15) == 0);
        return t;
    endfunction

    task automatic check_field(string name, logic signed [W-1:0] exp, logic [W-1:0] act);
        if (act !== exp)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        factors_t f;
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (factors_due.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual rx %h", $time, rx_term);
                errors++;
            end
            else
            begin
                f = factors_due.pop_front();
                if (f.degen)
                    degen_seen++;
                check_field("rx_term", f.rx, rx_term);
                check_field("ry_term", f.ry, ry_term);
                check_field("sx_term", f.sx, sx_term);
                check_field("sy_term", f.sy, sy_term);
                check_field("jacobian", f.jac, jacobian);
                check_field("degenerate", f.degen, degenerate);
                check_field("last_result", f.last, last_result);
            end
        end
        out_stall <= idle_on && ($urandom_range(99) < 37);
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, factors_due.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        row_t     rows[$];
        factors_t none;
        tri_t     t;
        none = '{0, 0, 0, 0, 0, 1'b0, 1'b0};
        rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0; last_element = 1'b0;
        x0_coord = '0; y0_coord = '0; x1_coord = '0;
        y1_coord = '0; x2_coord = '0; y2_coord = '0;

        // Typed rows: all-zero and collinear (degenerate), unit right triangle,
        // and a tiny nonzero Jacobian that rounds to zero and saturates the terms.
        rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 0, 0, 0, 0, 0, 1'b1));
        rows.push_back(mk_row(0, 0, 'h20000, 'h20000, 'h40000, 'h40000, 1'b1, 1'b1,
                              0, 0, 0, 0, 0, 1'b1));
        rows.push_back(mk_row(0, 0, 'h20000, 0, 0, 'h20000, 1'b0, 1'b1,
                              'h10000, 0, 0, 'h10000, 'h10000, 1'b0));
        rows.push_back(mk_row(0, 0, 2, 0, 0, 2, 1'b1, 1'b1,
                              'h7fffffff, 0, 0, 'h7fffffff, 0, 1'b0));
        rows.push_back(mk_row('h7fffffff, 'h7fffffff, 'h7fffffff, 'h7fffffff,
                              'h7fffffff, 'h7fffffff, 1'b0, 1'b1, 0, 0, 0, 0, 0, 1'b1));
        // Predicted rows: mirrored orientation, extremes, odd differences.
        rows.push_back(mk_row(0, 0, 0, 2, 2, 0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0));
        rows.push_back(mk_row(0, 0, 'h20000, 0, 0, -'h20000, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row('h80000000, 'h80000000, 'h7fffffff, 'h80000000,
                              'h80000000, 'h7fffffff, 1'b1, 1'b0, 0, 0, 0, 0, 0, 1'b0));
        rows.push_back(mk_row('h7fffffff, 'h7fffffff, 'h80000000, 'h7fffffff,
                              'h7fffffff, 'h80000000, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0));
        rows.push_back(mk_row('h80000000, 0, 'h7fffffff, 'h80000000, 0, 'h7fffffff,
                              1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0));
        rows.push_back(mk_row(0, 0, -1, 0, 0, -1, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0));
        rows.push_back(mk_row(-1, -1, 'h7fffffff, 0, 0, 'h7fffffff, 1'b1, 1'b0,
                              0, 0, 0, 0, 0, 1'b0));
        rows.push_back(mk_row('h12345, -'h6789a, 'h300000, 'h11111, -'h50000, 'h222222,
                              1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0));
        rows.push_back(mk_row('h10000, 'h10000, 'h10003, 'h10000, 'h10000, 'h10005,
                              1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0));
        rows.push_back(mk_row(3, 5, 'h40000000, 7, 9, 'h40000000, 1'b1, 1'b0,
                              0, 0, 0, 0, 0, 1'b0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_triangle(rows[i].t, rows[i].typed, rows[i].f);

        // Hold the sender off until the pipeline has delivered everything.
        in_valid <= 1'b0;
        while (factors_due.size() != 0)
            @(posedge clk);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            idle_on = !(n >= 400 && n < 700);
            t = rand_triangle();
            send_triangle(t, 1'b0, none);
        end
        in_valid <= 1'b0;
        idle_on = 1'b1;

        while (factors_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d triangles, checked %0d results, %0d of them degenerate.",
                 sent, results_seen, degen_seen);
        $display("Directed extremes, saturation and random streams with stalls done.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* triangle_geometric_factors.f */
design/tgf_pkg.sv
design/tgf_front.sv
design/tgf_queue.sv
design/tgf_back.sv
design/triangle_geometric_factors.sv
tb/sv/tb_triangle_geometric_factors.sv
